[src/sfs_pkg.sv]
package sfs_pkg;

	localparam int FRAME_W    = 12;
	localparam int POS_W      = 28;
	localparam int COORD_W    = 16;
	localparam int COUNT_W    = 13;
	localparam int PERIOD_W   = 32;
	localparam int ELAPSED_W  = 24;
	localparam int MODE_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int MAX_FRAMES    = 4096;
	localparam int TIME_BITS_DEF = 32;

	// One divider step per bit of the frame number.
	localparam int DIV_STEPS = FRAME_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int MODE_PAUSED    = 0;
	localparam int MODE_REVERSED  = 1;
	localparam int MODE_HOLD      = 2;
	localparam int MODE_MULTI_ROW = 3;

	typedef enum logic [1:0] {
		CMD_TICK      = 2'd0,
		CMD_SET_FRAME = 2'd1,
		CMD_RESTART   = 2'd2
	} command_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_LEFT    = 3'd0,
		REG_ORIGIN_TOP     = 3'd1,
		REG_CELL_WIDTH     = 3'd2,
		REG_CELL_HEIGHT    = 3'd3,
		REG_FRAMES_PER_ROW = 3'd4,
		REG_TOTAL_FRAMES   = 3'd5,
		REG_FRAME_PERIOD   = 3'd6,
		REG_MODE_BITS      = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		command_t               command;
		logic [ELAPSED_W-1:0]   elapsed_time;
		logic [FRAME_W-1:0]     frame_value;
	} cmd_item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_number;
		logic [POS_W-1:0]   cell_left;
		logic [POS_W-1:0]   cell_top;
		logic               finished;
	} res_item_t;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic div_step;
		logic mul;
		logic add;
		logic load_out;
	} dp_ctl_t;

	typedef struct packed {
		logic need_cell;
	} dp_status_t;

endpackage

[src/sfs_ctrl.sv]
module sfs_ctrl import sfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	output logic       res_valid,
	input  logic       res_ready,
	input  dp_status_t status,
	output dp_ctl_t    ctl
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_MUL,
		ST_ADD,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 cmd_ready_q;
	logic                 res_valid_q;
	logic                 out_free;

	assign cmd_ready = cmd_ready_q;
	assign res_valid = res_valid_q;

	// The output register may be refilled in the cycle its transfer completes.
	assign out_free = !res_valid_q || res_ready;

	always_comb begin
		ctl          = '0;
		ctl.load_in  = (state_q == ST_IDLE) && cmd_valid && cmd_ready_q;
		ctl.exec     = (state_q == ST_EXEC);
		ctl.div_step = (state_q == ST_DIV);
		ctl.mul      = (state_q == ST_MUL);
		ctl.add      = (state_q == ST_ADD);
		ctl.load_out = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			cmd_ready_q <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			if (ctl.load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid && cmd_ready_q) begin
						state_q     <= ST_EXEC;
						cmd_ready_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					if (status.need_cell) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q + DIV_CNT_W'(1);
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						cmd_ready_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[src/sfs_datapath.sv]
module sfs_datapath import sfs_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_item_t             cmd_data,
	input  dp_ctl_t               ctl,
	output dp_status_t            status,
	output res_item_t             res_data
);

	localparam int SUM_W    = ((TIME_BITS > ELAPSED_W) ? TIME_BITS : ELAPSED_W) + 1;
	localparam int CMP_W    = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W;
	localparam int MUL_L_W  = COORD_W + COUNT_W;
	localparam int TRIAL_W  = COUNT_W + 1;

	// Configuration registers.
	logic [COORD_W-1:0]  origin_left_q;
	logic [COORD_W-1:0]  origin_top_q;
	logic [COORD_W-1:0]  cell_width_q;
	logic [COORD_W-1:0]  cell_height_q;
	logic [COUNT_W-1:0]  frames_per_row_q;
	logic [COUNT_W-1:0]  total_frames_q;
	logic [PERIOD_W-1:0] frame_period_q;
	logic [MODE_W-1:0]   mode_q;

	// Sequencer state.
	logic [TIME_BITS-1:0] timer_q;
	logic [FRAME_W-1:0]   frame_q;
	logic                 end_q;
	logic [POS_W-1:0]     left_q;
	logic [POS_W-1:0]     top_q;

	// Working registers.
	cmd_item_t          item_q;
	logic [COUNT_W-1:0] rem_q;
	logic [FRAME_W-1:0] quo_q;
	logic [POS_W-1:0]   prod_left_q;
	logic [POS_W-1:0]   prod_top_q;
	res_item_t          res_q;

	logic [COUNT_W-1:0]   per;
	logic [COUNT_W-1:0]   total_eff;
	logic [COUNT_W-1:0]   last;
	logic [SUM_W-1:0]     sum;
	logic [TIME_BITS-1:0] timer_sat;
	logic                 period_reached;
	logic                 paused;
	logic                 reversed;
	logic                 held;
	logic                 step;
	logic [FRAME_W-1:0]   frame_n;
	logic [TIME_BITS-1:0] timer_n;
	logic                 end_n;
	logic                 cell_n;
	logic [TRIAL_W-1:0]   trial;
	logic                 trial_fits;
	logic [TRIAL_W-1:0]   trial_diff;
	logic [FRAME_W-1:0]   row;
	logic [MUL_L_W-1:0]   mul_left;
	logic [POS_W-1:0]     mul_top;

	// A zero count means one; the frame count is clamped to the supported maximum.
	assign per = (frames_per_row_q == '0) ? COUNT_W'(1) : frames_per_row_q;

	always_comb begin
		if (total_frames_q == '0) begin
			total_eff = COUNT_W'(1);
		end else if (32'(total_frames_q) > 32'(MAX_FRAMES)) begin
			total_eff = COUNT_W'(MAX_FRAMES);
		end else begin
			total_eff = total_frames_q;
		end
	end

	assign last = total_eff - COUNT_W'(1);

	assign sum       = SUM_W'(timer_q) + SUM_W'(item_q.elapsed_time);
	assign timer_sat = (|sum[SUM_W-1:TIME_BITS]) ? '1 : sum[TIME_BITS-1:0];

	assign period_reached = CMP_W'(timer_sat) >= CMP_W'(frame_period_q);
	assign paused         = mode_q[MODE_PAUSED];
	assign reversed       = mode_q[MODE_REVERSED];
	assign held           = mode_q[MODE_HOLD] && ({1'b0, frame_q} == last);
	assign step           = period_reached && !paused && !held;

	always_comb begin
		frame_n = frame_q;
		timer_n = timer_q;
		end_n   = end_q;
		cell_n  = 1'b0;
		case (item_q.command)
			CMD_TICK: begin
				timer_n = timer_sat;
				end_n   = 1'b0;
				cell_n  = 1'b1;
				if (step) begin
					if (end_q && reversed) begin
						frame_n = last[FRAME_W-1:0];
						timer_n = '0;
					end else if (reversed && frame_q == '0) begin
						// Ran off the first frame: park with the mark, timer kept.
						end_n  = 1'b1;
						cell_n = 1'b0;
					end else if (!reversed && !end_q && {1'b0, frame_q} >= last) begin
						frame_n = last[FRAME_W-1:0];
						end_n   = 1'b1;
						cell_n  = 1'b0;
					end else if (end_q && !reversed) begin
						frame_n = '0;
						timer_n = '0;
					end else begin
						frame_n = reversed ? frame_q - FRAME_W'(1) : frame_q + FRAME_W'(1);
						timer_n = '0;
					end
				end
			end
			CMD_SET_FRAME: begin
				frame_n = item_q.frame_value;
				timer_n = '0;
				cell_n  = 1'b1;
			end
			CMD_RESTART: begin
				frame_n = '0;
				timer_n = '0;
				end_n   = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign status.need_cell = cell_n;

	// Restoring divider: one quotient bit per step, dividend shifted out of quo_q.
	assign trial      = {rem_q, quo_q[FRAME_W-1]};
	assign trial_fits = trial >= {1'b0, per};
	assign trial_diff = trial - {1'b0, per};

	assign row      = mode_q[MODE_MULTI_ROW] ? quo_q : '0;
	assign mul_left = MUL_L_W'(cell_width_q) * MUL_L_W'(rem_q);
	assign mul_top  = POS_W'(cell_height_q) * POS_W'(row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_left_q    <= '0;
			origin_top_q     <= '0;
			cell_width_q     <= '0;
			cell_height_q    <= '0;
			frames_per_row_q <= COUNT_W'(1);
			total_frames_q   <= COUNT_W'(1);
			frame_period_q   <= '0;
			mode_q           <= '0;
			timer_q          <= '0;
			frame_q          <= '0;
			end_q            <= 1'b0;
			left_q           <= '0;
			top_q            <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_reg_t'(cfg_index))
					REG_ORIGIN_LEFT:    origin_left_q    <= cfg_data[COORD_W-1:0];
					REG_ORIGIN_TOP:     origin_top_q     <= cfg_data[COORD_W-1:0];
					REG_CELL_WIDTH:     cell_width_q     <= cfg_data[COORD_W-1:0];
					REG_CELL_HEIGHT:    cell_height_q    <= cfg_data[COORD_W-1:0];
					REG_FRAMES_PER_ROW: frames_per_row_q <= cfg_data[COUNT_W-1:0];
					REG_TOTAL_FRAMES:   total_frames_q   <= cfg_data[COUNT_W-1:0];
					REG_FRAME_PERIOD:   frame_period_q   <= cfg_data[PERIOD_W-1:0];
					REG_MODE_BITS:      mode_q           <= cfg_data[MODE_W-1:0];
					default: begin
					end
				endcase
			end
			if (ctl.exec) begin
				timer_q <= timer_n;
				frame_q <= frame_n;
				end_q   <= end_n;
			end
			if (ctl.add) begin
				left_q <= POS_W'(origin_left_q) + prod_left_q;
				top_q  <= POS_W'(origin_top_q) + prod_top_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			item_q <= cmd_data;
		end
		if (ctl.exec) begin
			rem_q <= '0;
			quo_q <= frame_n;
		end
		if (ctl.div_step) begin
			if (trial_fits) begin
				rem_q <= trial_diff[COUNT_W-1:0];
				quo_q <= {quo_q[FRAME_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[COUNT_W-1:0];
				quo_q <= {quo_q[FRAME_W-2:0], 1'b0};
			end
		end
		if (ctl.mul) begin
			prod_left_q <= mul_left[POS_W-1:0];
			prod_top_q  <= mul_top;
		end
		if (ctl.load_out) begin
			res_q.frame_number <= frame_q;
			res_q.cell_left    <= left_q;
			res_q.cell_top     <= top_q;
			res_q.finished     <= end_q;
		end
	end

	assign res_data = res_q;

endmodule

[src/sprite_frame_sequencer_core.sv]
// Channel  Signals                                   Moves
// cfg      cfg_valid cfg_ready cfg_index cfg_data    one register write
// cmd      cmd_valid cmd_ready cmd_data              one command item
// res      res_valid res_ready res_data              one result item
//
// A tick or set frame that moves the cell passes through the 12-step divider that
// splits the frame into column and row, then the multiply and add states; the
// result is loaded into the output register after the add. Restart, a tick that
// finishes, and an unused command skip the divider and go straight to the result.
// Reset is asynchronous and active low; no clearing pass follows it.
// A result waiting in the output register does not stop the next command
// transfer, only the loading of the following result.
module sprite_frame_sequencer_core import sfs_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  cmd_item_t             cmd_data,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_item_t             res_data
);

	dp_ctl_t    ctl;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	sfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.status    (status),
		.ctl       (ctl)
	);

	sfs_datapath #(
		.TIME_BITS (TIME_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_data  (cmd_data),
		.ctl       (ctl),
		.status    (status),
		.res_data  (res_data)
	);

endmodule

[src/sfs_checker.sv]
module sfs_checker import sfs_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_ready,
	input logic      res_valid,
	input logic      res_ready,
	input res_item_t res_data
);

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// Only one command is in flight at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while busy");

	// No result can appear in the cycle straight after a command transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && !res_valid |=> !res_valid)
		else $error("result appeared too early");

	// A new result is only loaded while the command side is closed.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !$past(cmd_ready))
		else $error("result loaded while idle");

endmodule

bind sprite_frame_sequencer_core sfs_checker u_sfs_checker (.*);

[verif/testbench.sv]
module testbench;
	import sfs_pkg::*;

	// The one command code that the package leaves unnamed; the block must ignore it.
	localparam command_t CMD_UNUSED = command_t'(2'd3);

	typedef struct {
		bit          is_write;
		cfg_reg_t    index;
		logic [31:0] value;
		cmd_item_t   item;
		bit          typed;
		res_item_t   want;
	} plan_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_reg_t              cfg_index = REG_ORIGIN_LEFT;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  cmd_valid = 1'b0;
	logic                  cmd_ready;
	cmd_item_t             cmd_data  = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	res_item_t             res_data;

	sprite_frame_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_data  (cmd_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	always #10 clk = ~clk;

	// Own copy of the registers, updated on every register transfer.
	logic [COORD_W-1:0]  r_origin_left = '0;
	logic [COORD_W-1:0]  r_origin_top  = '0;
	logic [COORD_W-1:0]  r_cell_w      = '0;
	logic [COORD_W-1:0]  r_cell_h      = '0;
	logic [COUNT_W-1:0]  r_per_row     = 13'd1;
	logic [COUNT_W-1:0]  r_total       = 13'd1;
	logic [PERIOD_W-1:0] r_period      = '0;
	logic [MODE_W-1:0]   r_mode        = '0;

	// Own copy of the sequencer state.
	logic [TIME_BITS_DEF-1:0] seq_timer    = '0;
	logic [FRAME_W-1:0]       seq_frame    = '0;
	logic                     seq_finished = 1'b0;
	logic [POS_W-1:0]         seq_left     = '0;
	logic [POS_W-1:0]         seq_top      = '0;

	res_item_t expected_frames[$];
	int        mismatches      = 0;
	int        idle_pct        = 0;
	int        stall_pct       = 0;
	bit        item_typed      = 1'b0;
	res_item_t item_want       = '0;
	bit        items_since_cfg = 1'b0;
	plan_row_t plan[$];

	function automatic void place_cell();
		logic [COUNT_W-1:0] per;
		logic [63:0]        col;
		logic [63:0]        row;
		logic [63:0]        wide;
		per = (r_per_row == '0) ? 13'd1 : r_per_row;
		col = 64'({1'b0, seq_frame} % per);
		row = r_mode[MODE_MULTI_ROW] ? 64'({1'b0, seq_frame} / per) : 64'd0;
		wide = 64'(r_origin_left) + 64'(r_cell_w) * col;
		seq_left = wide[POS_W-1:0];
		wide = 64'(r_origin_top) + 64'(r_cell_h) * row;
		seq_top = wide[POS_W-1:0];
	endfunction

	function automatic res_item_t advance_sequencer(cmd_item_t c);
		logic [TIME_BITS_DEF:0] sum;
		int                     total;
		int                     f;
		bit                     rev;
		bit                     parked;
		res_item_t              r;
		parked = 1'b0;
		case (c.command)
			CMD_TICK: begin
				sum = {1'b0, seq_timer} + (TIME_BITS_DEF+1)'(c.elapsed_time);
				seq_timer = sum[TIME_BITS_DEF] ? '1 : sum[TIME_BITS_DEF-1:0];
				total = (r_total == '0) ? 1 : int'(r_total);
				if (total > MAX_FRAMES)
					total = MAX_FRAMES;
				rev = r_mode[MODE_REVERSED];
				if (seq_timer >= r_period && !r_mode[MODE_PAUSED] &&
						!(r_mode[MODE_HOLD] && int'(seq_frame) == total - 1)) begin
					f = int'(seq_frame) + (rev ? -1 : 1);
					if (seq_finished && rev) begin
						f = total - 1;
						seq_finished = 1'b0;
					end else if (f < 0 && rev) begin
						seq_frame = '0;
						seq_finished = 1'b1;
						parked = 1'b1;
					end else if (f > total - 1 && !rev && !seq_finished) begin
						seq_frame = FRAME_W'(total - 1);
						seq_finished = 1'b1;
						parked = 1'b1;
					end else if (seq_finished && !rev) begin
						f = 0;
						seq_finished = 1'b0;
					end
					if (!parked) begin
						seq_frame = FRAME_W'(f);
						seq_timer = '0;
					end
				end
				// A finishing step leaves the timer and the cell position alone.
				if (!parked) begin
					seq_finished = 1'b0;
					place_cell();
				end
			end
			CMD_SET_FRAME: begin
				seq_frame = c.frame_value;
				seq_timer = '0;
				place_cell();
			end
			CMD_RESTART: begin
				seq_frame = '0;
				seq_timer = '0;
				seq_finished = 1'b0;
			end
			default: ;
		endcase
		r.frame_number = seq_frame;
		r.cell_left    = seq_left;
		r.cell_top     = seq_top;
		r.finished     = seq_finished;
		return r;
	endfunction

	always @(posedge clk) begin
		res_item_t want;
		res_item_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ORIGIN_LEFT:    r_origin_left = cfg_data[COORD_W-1:0];
					REG_ORIGIN_TOP:     r_origin_top  = cfg_data[COORD_W-1:0];
					REG_CELL_WIDTH:     r_cell_w      = cfg_data[COORD_W-1:0];
					REG_CELL_HEIGHT:    r_cell_h      = cfg_data[COORD_W-1:0];
					REG_FRAMES_PER_ROW: r_per_row     = cfg_data[COUNT_W-1:0];
					REG_TOTAL_FRAMES:   r_total       = cfg_data[COUNT_W-1:0];
					REG_FRAME_PERIOD:   r_period      = cfg_data[PERIOD_W-1:0];
					REG_MODE_BITS:      r_mode        = cfg_data[MODE_W-1:0];
					default: ;
				endcase
			end
			if (cmd_valid && cmd_ready) begin
				want = advance_sequencer(cmd_data);
				expected_frames = {expected_frames, (item_typed ? item_want : want)};
			end
			if (res_valid && res_ready) begin
				got = res_data;
				if (expected_frames.size() == 0) begin
					$error("result transfer with nothing expected: %p", got);
					mismatches++;
				end else begin
					want = expected_frames.pop_front();
					if (got.frame_number !== want.frame_number) begin
						$error("frame_number: expected %0d, got %0d",
							want.frame_number, got.frame_number);
						mismatches++;
					end
					if (got.cell_left !== want.cell_left) begin
						$error("cell_left: expected %0h, got %0h", want.cell_left, got.cell_left);
						mismatches++;
					end
					if (got.cell_top !== want.cell_top) begin
						$error("cell_top: expected %0h, got %0h", want.cell_top, got.cell_top);
						mismatches++;
					end
					if (got.finished !== want.finished) begin
						$error("finished: expected %0b, got %0b", want.finished, got.finished);
						mismatches++;
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		res_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
	end

	// Stop presenting commands and wait until every result has come back.
	task automatic settle();
		@(negedge clk);
		cmd_valid <= 1'b0;
		cfg_valid <= 1'b0;
		wait (expected_frames.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		if (items_since_cfg) begin
			settle();
			items_since_cfg = 1'b0;
		end
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic send_item(cmd_item_t it, bit typed, res_item_t want);
		int gap;
		gap = 0;
		@(negedge clk);
		cfg_valid <= 1'b0;
		while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_data   <= it;
		cmd_valid  <= 1'b1;
		item_typed = typed;
		item_want  = want;
		items_since_cfg = 1'b1;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
	endtask

	function automatic void add_row(plan_row_t r);
		plan = {plan, r};
	endfunction

	function automatic plan_row_t reg_row(cfg_reg_t idx, logic [31:0] val);
		plan_row_t r;
		r = '{index: REG_ORIGIN_LEFT, default: '0};
		r.is_write = 1'b1;
		r.index    = idx;
		r.value    = val;
		return r;
	endfunction

	function automatic plan_row_t cmd_row(command_t op, logic [ELAPSED_W-1:0] el,
			logic [FRAME_W-1:0] fv);
		plan_row_t r;
		r = '{index: REG_ORIGIN_LEFT, default: '0};
		r.item.command      = op;
		r.item.elapsed_time = el;
		r.item.frame_value  = fv;
		return r;
	endfunction

	function automatic plan_row_t checked_row(command_t op, logic [ELAPSED_W-1:0] el,
			logic [FRAME_W-1:0] fv, logic [FRAME_W-1:0] fn, logic [POS_W-1:0] left,
			logic [POS_W-1:0] top, logic fin);
		plan_row_t r;
		r = cmd_row(op, el, fv);
		r.typed             = 1'b1;
		r.want.frame_number = fn;
		r.want.cell_left    = left;
		r.want.cell_top     = top;
		r.want.finished     = fin;
		return r;
	endfunction

	function automatic logic [31:0] pick_coord();
		logic [31:0] junk;
		junk = $urandom();
		case ($urandom_range(0, 3))
			0:       return {junk[31:16], 16'h0000};
			1:       return {junk[31:16], 16'hFFFF};
			default: return junk;
		endcase
	endfunction

	function automatic logic [31:0] pick_count(bit is_total);
		logic [31:0] junk;
		junk = $urandom();
		case ($urandom_range(0, 7))
			0:       return {junk[31:13], 13'd0};
			1:       return {junk[31:13], 13'd1};
			2:       return {junk[31:13], 13'd4096};
			3:       return is_total ? {junk[31:13], 13'h1FFF} : junk;
			default: return {junk[31:13], 13'($urandom_range(2, 8))};
		endcase
	endfunction

	task automatic random_setup();
		logic [MODE_W-1:0] mode;
		mode = MODE_W'($urandom());
		if (mode[MODE_PAUSED] && $urandom_range(0, 2) != 0)
			mode[MODE_PAUSED] = 1'b0;
		write_reg(REG_ORIGIN_LEFT, pick_coord());
		write_reg(REG_ORIGIN_TOP, pick_coord());
		write_reg(REG_CELL_WIDTH, pick_coord());
		write_reg(REG_CELL_HEIGHT, pick_coord());
		write_reg(REG_FRAMES_PER_ROW, pick_count(1'b0));
		write_reg(REG_TOTAL_FRAMES, pick_count(1'b1));
		write_reg(REG_FRAME_PERIOD, ($urandom_range(0, 4) == 0) ? 32'd0 :
			32'($urandom_range(0, 32'h30000)));
		write_reg(REG_MODE_BITS, {28'($urandom()), mode});
	endtask

	function automatic cmd_item_t random_item();
		cmd_item_t  c;
		int unsigned pick;
		int unsigned span;
		c.elapsed_time = ($urandom_range(0, 5) == 0) ? ELAPSED_W'($urandom()) :
			ELAPSED_W'($urandom_range(0, 24'h20000));
		span = (r_total == '0) ? 2 : int'(r_total) + 1;
		c.frame_value = ($urandom_range(0, 3) == 0) ? FRAME_W'($urandom()) :
			FRAME_W'($urandom_range(0, (span > 4095) ? 4095 : span));
		pick = $urandom_range(0, 19);
		if (pick < 12)
			c.command = CMD_TICK;
		else if (pick < 16)
			c.command = CMD_SET_FRAME;
		else if (pick < 19)
			c.command = CMD_RESTART;
		else
			c.command = CMD_UNUSED;
		return c;
	endfunction

	initial begin
		cmd_item_t c;
		int        count;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values: one frame, zero period, so every tick finishes or wraps.
		add_row(checked_row(CMD_TICK, 24'h000000, 12'h000, 12'h000, 28'h0, 28'h0, 1'b1));
		add_row(checked_row(CMD_TICK, 24'hFFFFFF, 12'h000, 12'h000, 28'h0, 28'h0, 1'b0));
		add_row(checked_row(CMD_RESTART, 24'hFFFFFF, 12'hFFF, 12'h000, 28'h0, 28'h0,
			1'b0));
		add_row(checked_row(CMD_UNUSED, 24'hFFFFFF, 12'hFFF, 12'h000, 28'h0, 28'h0,
			1'b0));
		// Coordinates and period at their top values, both counts at 4096, multi-row mode on.
		add_row(reg_row(REG_ORIGIN_LEFT, 32'h0000FFFF));
		add_row(reg_row(REG_ORIGIN_TOP, 32'h0000FFFF));
		add_row(reg_row(REG_CELL_WIDTH, 32'h0000FFFF));
		add_row(reg_row(REG_CELL_HEIGHT, 32'h0000FFFF));
		add_row(reg_row(REG_FRAMES_PER_ROW, 32'd4096));
		add_row(reg_row(REG_TOTAL_FRAMES, 32'd4096));
		add_row(reg_row(REG_FRAME_PERIOD, 32'hFFFFFFFF));
		add_row(reg_row(REG_MODE_BITS, 32'd8));
		add_row(checked_row(CMD_SET_FRAME, 24'hFFFFFF, 12'hFFF, 12'hFFF, 28'hFFFF000,
			28'h000FFFF, 1'b0));
		add_row(cmd_row(CMD_TICK, 24'hFFFFFF, 12'h000));
		add_row(reg_row(REG_FRAMES_PER_ROW, 32'd1));
		add_row(checked_row(CMD_SET_FRAME, 24'h000000, 12'hFFF, 12'hFFF, 28'h000FFFF,
			28'hFFFF000, 1'b0));
		// Reverse play over three frames: finish at frame zero, then wrap to the end.
		add_row(reg_row(REG_ORIGIN_LEFT, 32'd10));
		add_row(reg_row(REG_ORIGIN_TOP, 32'd20));
		add_row(reg_row(REG_CELL_WIDTH, 32'd3));
		add_row(reg_row(REG_CELL_HEIGHT, 32'd5));
		add_row(reg_row(REG_FRAMES_PER_ROW, 32'd2));
		add_row(reg_row(REG_TOTAL_FRAMES, 32'd3));
		add_row(reg_row(REG_FRAME_PERIOD, 32'd0));
		add_row(reg_row(REG_MODE_BITS, 32'd10));
		add_row(cmd_row(CMD_RESTART, 24'h000000, 12'h000));
		add_row(cmd_row(CMD_TICK, 24'h000000, 12'h000));
		add_row(cmd_row(CMD_TICK, 24'h000001, 12'h000));
		add_row(cmd_row(CMD_SET_FRAME, 24'h000000, 12'd4000));
		add_row(cmd_row(CMD_TICK, 24'h000005, 12'h000));
		// Hold on the last frame, and a forward step from beyond the frame count.
		add_row(reg_row(REG_MODE_BITS, 32'd4));
		add_row(cmd_row(CMD_SET_FRAME, 24'h000000, 12'd2));
		add_row(cmd_row(CMD_TICK, 24'h000064, 12'h000));
		add_row(cmd_row(CMD_SET_FRAME, 24'h000000, 12'd4000));
		add_row(cmd_row(CMD_TICK, 24'h000007, 12'h000));
		add_row(cmd_row(CMD_TICK, 24'h000000, 12'h000));
		add_row(reg_row(REG_MODE_BITS, 32'd1));
		add_row(cmd_row(CMD_TICK, 24'hFFFFFF, 12'h000));
		// Zero divisor and zero frame count both count as one.
		add_row(reg_row(REG_FRAMES_PER_ROW, 32'd0));
		add_row(reg_row(REG_TOTAL_FRAMES, 32'd0));
		add_row(reg_row(REG_MODE_BITS, 32'd8));
		add_row(cmd_row(CMD_SET_FRAME, 24'h000000, 12'd5));
		add_row(cmd_row(CMD_TICK, 24'h000000, 12'h000));
		add_row(cmd_row(CMD_TICK, 24'h000000, 12'h000));
		// A frame count above the limit is clipped to it.
		add_row(reg_row(REG_TOTAL_FRAMES, 32'h00001FFF));
		add_row(reg_row(REG_MODE_BITS, 32'd0));
		add_row(reg_row(REG_FRAME_PERIOD, 32'h00010000));
		add_row(cmd_row(CMD_SET_FRAME, 24'h000000, 12'hFFF));
		add_row(cmd_row(CMD_TICK, 24'h010000, 12'h000));
		add_row(cmd_row(CMD_TICK, 24'h000000, 12'h000));

		foreach (plan[i]) begin
			if (plan[i].is_write)
				write_reg(plan[i].index, plan[i].value);
			else
				send_item(plan[i].item, plan[i].typed, plan[i].want);
		end

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 84; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 84; end
				default: begin idle_pct = 23; stall_pct = 23; end
			endcase
			if (p == 3) begin
				// Longest period: the timer has to saturate before the frame can move.
				write_reg(REG_ORIGIN_LEFT, pick_coord());
				write_reg(REG_ORIGIN_TOP, pick_coord());
				write_reg(REG_CELL_WIDTH, pick_coord());
				write_reg(REG_CELL_HEIGHT, pick_coord());
				write_reg(REG_FRAMES_PER_ROW, 32'd3);
				write_reg(REG_TOTAL_FRAMES, 32'd4);
				write_reg(REG_FRAME_PERIOD, 32'hFFFFFFFF);
				write_reg(REG_MODE_BITS, 32'd8);
				count = 280;
			end else begin
				random_setup();
				count = 28;
			end
			for (int n = 0; n < count; n++) begin
				if (p == 3) begin
					c.command      = CMD_TICK;
					c.frame_value  = FRAME_W'($urandom());
					c.elapsed_time = $urandom_range(0, 1) ? 24'hFFFFFF :
						ELAPSED_W'($urandom_range(24'hF00000, 24'hFFFFFF));
				end else begin
					c = random_item();
				end
				send_item(c, 1'b0, '0);
			end
		end

		settle();
		idle_pct  = 0;
		stall_pct = 0;
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_frames.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#8000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

[sim.f]
src/sfs_pkg.sv
src/sfs_ctrl.sv
src/sfs_datapath.sv
src/sprite_frame_sequencer_core.sv
src/sfs_checker.sv
verif/testbench.sv
